>>> sv/pmft_pkg.sv
// ----------------------------------------------------------------------------
// pmft_pkg
// Shared types and fixed field widths for the prefix-maximum Fenwick tree.
// ----------------------------------------------------------------------------
package pmft_pkg;

   // field widths fixed by the interface
   localparam int POS_W  = 13;
   localparam int VAL_W  = 16;
   localparam int OP_W   = 2;
   // walk register: an upward step from a 13-bit position can carry one bit
   localparam int WALK_W = POS_W + 1;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_UPDATE = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

endpackage

>>> sv/prefix_max_fenwick_tree.sv
// ----------------------------------------------------------------------------
// prefix_max_fenwick_tree
// Binary indexed tree of running maxima held in one simple dual-port RAM.
// ----------------------------------------------------------------------------
// Handles one operation at a time; req_stall is high while an operation runs.
// The RAM has one read and one write port with registered read data, so a
// tree walk visits one node at a time: an update visits each covering node
// up to the active size (at most 13 for a 4096-entry tree), a query steps
// through one node per set bit of the position, and its result then sits in
// an output register, so the next operation can start while the result waits.
// A clear sweeps the RAM one entry per cycle; the same sweep runs after reset,
// and no transfer is taken until it finishes (csr writes are taken at any time).
// ----------------------------------------------------------------------------
module prefix_max_fenwick_tree
   import pmft_pkg::*;
#(
   parameter int TREE_SIZE = 4096
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [OP_W-1:0]  req_operation,
   input  logic [POS_W-1:0] req_position,
   input  logic [VAL_W-1:0] req_new_value,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [VAL_W-1:0] rsp_prefix_maximum,
   // configuration
   input  logic             csr_wr_en,
   input  logic [POS_W-1:0] csr_wr_data
);

   localparam int AW = $clog2(TREE_SIZE);
   // largest update limit reachable with a POS_W-bit active size
   localparam int LIMIT_MAX = (TREE_SIZE > (2 ** POS_W) - 1) ? (2 ** POS_W) - 1 : TREE_SIZE;
   localparam logic [POS_W-1:0] LIMIT_CAP = POS_W'(LIMIT_MAX);
   localparam logic [AW-1:0]    LAST_ADDR = AW'(TREE_SIZE - 1);
   localparam logic [POS_W-1:0] ACTIVE_RST = 13'd4096;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_QUERY
   } state_type;

   // registers
   state_type          state_ff,      state_in;
   logic [WALK_W-1:0]  walk_ff,       walk_in;
   logic [VAL_W-1:0]   best_ff,       best_in;
   logic [VAL_W-1:0]   value_ff,      value_in;
   logic [POS_W-1:0]   limit_ff,      limit_in;
   logic               rd_pend_ff,    rd_pend_in;
   logic [AW-1:0]      clr_addr_ff,   clr_addr_in;
   logic               rsp_valid_ff,  rsp_valid_in;
   logic [VAL_W-1:0]   rsp_max_ff,    rsp_max_in;
   logic [POS_W-1:0]   active_ff;
   logic [VAL_W-1:0]   rd_data_ff;

   // tree storage, node p at entry p-1
   logic [VAL_W-1:0]   tree_mem [TREE_SIZE];

   // RAM port controls
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [VAL_W-1:0]   mem_wdata;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;

   // walk arithmetic
   logic [WALK_W-1:0]  req_pos_w;
   logic [WALK_W-1:0]  up_nxt;
   logic [WALK_W-1:0]  dn_nxt;
   logic [POS_W-1:0]   limit_now;
   logic               req_in_store;
   logic               dn_in_store;
   logic [VAL_W-1:0]   best_nxt;
   logic               out_free;

   assign req_pos_w    = WALK_W'(req_position);
   assign up_nxt       = walk_ff + (walk_ff & (~walk_ff + WALK_W'(1)));
   assign dn_nxt       = walk_ff & (walk_ff - WALK_W'(1));
   assign limit_now    = (active_ff > LIMIT_CAP) ? LIMIT_CAP : active_ff;
   assign req_in_store = (req_pos_w != '0) && (32'(req_pos_w) <= 32'(TREE_SIZE));
   assign dn_in_store  = (dn_nxt != '0) && (32'(dn_nxt) <= 32'(TREE_SIZE));
   assign best_nxt     = (rd_pend_ff && (rd_data_ff > best_ff)) ? rd_data_ff : best_ff;
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // next-state and RAM control
   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      best_in      = best_ff;
      value_in     = value_ff;
      limit_in     = limit_ff;
      rd_pend_in   = rd_pend_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_max_in   = rsp_max_ff;
      mem_we       = 1'b0;
      mem_waddr    = AW'(walk_ff - WALK_W'(1));
      mem_wdata    = value_ff;
      rd_en        = 1'b0;
      rd_addr      = AW'(req_pos_w - WALK_W'(1));

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = '0;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (op_type'(req_operation))
                  OP_UPDATE: begin
                     // position zero or past the limit changes nothing
                     if ((req_position != '0) && (req_position <= limit_now)) begin
                        rd_en    = 1'b1;
                        walk_in  = req_pos_w;
                        value_in = req_new_value;
                        limit_in = limit_now;
                        state_in = ST_UPDATE;
                     end
                  end
                  OP_QUERY: begin
                     rd_en      = req_in_store;
                     rd_pend_in = req_in_store;
                     walk_in    = req_pos_w;
                     best_in    = '0;
                     state_in   = ST_QUERY;
                  end
                  OP_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  default: begin
                     // unused code, dropped
                  end
               endcase
            end
         end
         ST_UPDATE: begin
            // raise this node, fetch the next covering one
            mem_we = (rd_data_ff < value_ff);
            if (up_nxt <= {1'b0, limit_ff}) begin
               rd_en   = 1'b1;
               rd_addr = AW'(up_nxt - WALK_W'(1));
               walk_in = up_nxt;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            if ((walk_ff == '0) || (dn_nxt == '0)) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_max_in   = best_nxt;
                  state_in     = ST_IDLE;
               end else begin
                  // park the result until the output register frees up
                  walk_in    = '0;
                  rd_pend_in = 1'b0;
                  best_in    = best_nxt;
               end
            end else begin
               rd_en      = dn_in_store;
               rd_addr    = AW'(dn_nxt - WALK_W'(1));
               rd_pend_in = dn_in_store;
               walk_in    = dn_nxt;
               best_in    = best_nxt;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         walk_ff      <= '0;
         best_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
         walk_ff      <= walk_in;
         best_ff      <= best_in;
      end
      value_ff   <= value_in;
      limit_ff   <= limit_in;
      rsp_max_ff <= rsp_max_in;
   end

   // active size register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RST;
      end else if (csr_wr_en) begin
         active_ff <= csr_wr_data;
      end
   end

   // RAM write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tree_mem[mem_waddr] <= mem_wdata;
      end
   end

   // RAM read port, registered data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= tree_mem[rd_addr];
      end
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_prefix_maximum = rsp_max_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // update writes stay inside the active range
   a_upd_in_limit: assert property (@(posedge clock) disable iff (reset)
      (mem_we && (state_ff == ST_UPDATE)) |->
         ((walk_ff != '0) && (walk_ff <= {1'b0, limit_ff})))
      else $error("update write outside the active range");

   // query at position zero with a free output returns zero through the query state and the output register
   a_query_zero: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_operation == OP_QUERY) &&
       (req_position == '0) && !rsp_valid) |=> ##1
         (rsp_valid && (rsp_prefix_maximum == '0)))
      else $error("query at position zero did not return zero");

   // an update at position zero leaves the block idle
   a_upd_zero_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_operation == OP_UPDATE) &&
       (req_position == '0)) |=> (state_ff == ST_IDLE))
      else $error("update at position zero started a walk");

   // a query walk only reads nodes that exist
   a_query_read: assert property (@(posedge clock) disable iff (reset)
      (rd_pend_ff && (state_ff == ST_QUERY)) |->
         ((walk_ff != '0) && (32'(walk_ff) <= 32'(TREE_SIZE))))
      else $error("query read past the store");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for prefix_max_fenwick_tree. A scoreboard class keeps
// its own copy of the tree and the active size, predicts each query result
// from the requests seen on the request channel, and compares every response
// in order. Directed corner cases come first, then random phases that run
// under several active sizes and different sender/receiver stall mixes.
// ----------------------------------------------------------------------------
module tb;
   import pmft_pkg::*;

   localparam int TREE_SIZE    = 4096;
   localparam int POS_MAX      = (1 << POS_W) - 1;
   localparam int VAL_MAX      = (1 << VAL_W) - 1;
   localparam int CLK_HALF     = 2;
   localparam int RESET_CYCLES = 12;
   // a clear sweeps every entry, so wait that long before touching the size
   localparam int SWEEP_CYCLES = TREE_SIZE + 64;
   localparam int TAIL_CYCLES  = 64;
   localparam int HOLD_CYCLES  = 400;
   localparam int FLOOD_ITEMS  = 30;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASES       = 7;
   localparam int PHASE_ITEMS  = 105;
   localparam int REPORT_LIMIT = 10;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   // sized copies of the range ends for driving the ports
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(TREE_SIZE);
   localparam logic [POS_W-1:0] TOP_POS  = POS_W'(POS_MAX);
   localparam logic [VAL_W-1:0] TOP_VAL  = VAL_W'(VAL_MAX);

   // -------------------------------------------------------------------------
   // Scoreboard: tree of running maxima plus queue of predicted query results
   // -------------------------------------------------------------------------
   class max_tree_scoreboard;
      logic [VAL_W-1:0] node_max [TREE_SIZE];
      int unsigned      size_reg;
      logic [VAL_W-1:0] expected_maxima [$];
      int unsigned      failures;

      function new();
         clear_nodes();
         size_reg = TREE_SIZE;
         failures = 0;
      endfunction

      function void clear_nodes();
         foreach (node_max[i]) node_max[i] = '0;
      endfunction

      function void set_active_size(logic [POS_W-1:0] value);
         size_reg = 32'(value);
      endfunction

      function int unsigned walk_limit();
         return (size_reg < TREE_SIZE) ? size_reg : TREE_SIZE;
      endfunction

      function int unsigned pending();
         return expected_maxima.size();
      endfunction

      // upward walk: add lowest set bit, stop at the active limit
      function void raise_path(int unsigned pos, logic [VAL_W-1:0] value);
         int unsigned limit;
         limit = walk_limit();
         while (pos != 0 && pos <= limit) begin
            if (node_max[pos-1] < value) node_max[pos-1] = value;
            pos += pos & (~pos + 1);
         end
      endfunction

      // downward walk: clear lowest set bit, nodes past the store read as zero
      function logic [VAL_W-1:0] prefix_max(int unsigned pos);
         logic [VAL_W-1:0] best;
         best = '0;
         while (pos != 0) begin
            if (pos <= TREE_SIZE && node_max[pos-1] > best) best = node_max[pos-1];
            pos &= pos - 1;
         end
         return best;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic [VAL_W-1:0] value);
         case (op)
            OP_UPDATE: raise_path(32'(pos), value);
            OP_QUERY:  expected_maxima.push_back(prefix_max(32'(pos)));
            OP_CLEAR:  clear_nodes();
            default: ;
         endcase
      endfunction

      function void report_failure(string msg);
         if (failures < REPORT_LIMIT) $display("[%0t] ERROR: %s", $time, msg);
         failures++;
      endfunction

      function void check_result(logic [VAL_W-1:0] actual);
         logic [VAL_W-1:0] expected;
         if (expected_maxima.size() == 0) begin
            report_failure($sformatf("unexpected result, prefix_maximum=%0d", actual));
            return;
         end
         expected = expected_maxima.pop_front();
         if (actual !== expected)
            report_failure($sformatf("prefix_maximum expected %0d, got %0d",
                                     expected, actual));
      endfunction

      function void check_drained();
         if (expected_maxima.size() != 0)
            report_failure($sformatf("%0d results never arrived",
                                     expected_maxima.size()));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and block under test
   // -------------------------------------------------------------------------
   logic             clock         = 1'b0;
   logic             reset         = 1'b1;
   logic             req_valid     = 1'b0;
   logic             req_stall;
   logic [OP_W-1:0]  req_operation = '0;
   logic [POS_W-1:0] req_position  = '0;
   logic [VAL_W-1:0] req_new_value = '0;
   logic             rsp_valid;
   logic             rsp_stall     = 1'b0;
   logic [VAL_W-1:0] rsp_prefix_maximum;
   logic             csr_wr_en     = 1'b0;
   logic [POS_W-1:0] csr_wr_data   = '0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          hold_on       = 1'b0;

   max_tree_scoreboard sb;

   prefix_max_fenwick_tree #(
      .TREE_SIZE (TREE_SIZE)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_position       (req_position),
      .req_new_value      (req_new_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_prefix_maximum (rsp_prefix_maximum),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always #(CLK_HALF) clock = ~clock;

   // transfer monitor: check responses before noting a new request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_prefix_maximum);
         if (req_valid && !req_stall)
            sb.note_request(req_operation, req_position, req_new_value);
      end
   end

   // receiver: random stalls, plus a long hold-off counted here
   initial begin : result_side
      int unsigned held;
      held = 0;
      forever begin
         @(negedge clock);
         if (hold_on) begin
            held++;
            if (held >= HOLD_CYCLES) begin
               hold_on = 1'b0;
               held    = 0;
            end
         end
         rsp_stall <= hold_on || ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // run limit
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   task automatic send_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                            logic [VAL_W-1:0] value);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_position  <= pos;
      req_new_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_active_size(logic [POS_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_active_size(value);
   endtask

   function automatic logic [OP_W-1:0] pick_operation();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 48) return OP_UPDATE;
      if (r < 94) return OP_QUERY;
      if (r < 96) return OP_CLEAR;
      return OP_UNUSED;
   endfunction

   // mostly inside the active range, some zero, some past the limit
   function automatic logic [POS_W-1:0] pick_position(int unsigned limit);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 16 || limit == 0) return POS_W'($urandom_range(0, POS_MAX));
      if (r < 24) return POS_W'($urandom_range(limit + 1, POS_MAX));
      return POS_W'($urandom_range(1, limit));
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return TOP_VAL;
      return VAL_W'($urandom_range(0, VAL_MAX));
   endfunction

   // corner cases on an empty tree with the full active size
   task automatic run_directed();
      send_item(OP_QUERY,  '0,                 '0);
      send_item(OP_QUERY,  LAST_POS,           '0);
      send_item(OP_UPDATE, '0,                 TOP_VAL);
      send_item(OP_QUERY,  LAST_POS,           '0);
      send_item(OP_UPDATE, 13'd1,              16'd5);
      send_item(OP_UPDATE, LAST_POS,           TOP_VAL);
      send_item(OP_QUERY,  LAST_POS - 13'd1,   '0);
      send_item(OP_QUERY,  LAST_POS,           '0);
      send_item(OP_UPDATE, LAST_POS + 13'd1,   16'd40000);
      send_item(OP_QUERY,  TOP_POS,            '0);
      send_item(OP_UPDATE, LAST_POS - 13'd1,   '0);
      send_item(OP_UNUSED, TOP_POS,            TOP_VAL);
      send_item(OP_QUERY,  13'd1,              '0);
      send_item(OP_UPDATE, 13'h0AAA,           16'h5555);
      send_item(OP_QUERY,  13'h0AAA,           '0);
      send_item(OP_UPDATE, 13'h0555,           16'hAAAA);
      send_item(OP_QUERY,  13'h07FF,           '0);
      send_item(OP_QUERY,  13'h1555,           '0);
      send_item(OP_CLEAR,  '0,                 '0);
      send_item(OP_QUERY,  LAST_POS,           '0);
      send_item(OP_QUERY,  TOP_POS,            '0);
      send_item(OP_UPDATE, TOP_POS,            16'd1);
      send_item(OP_UPDATE, 13'd3,              TOP_VAL);
      send_item(OP_QUERY,  13'd3,              '0);
   endtask

   task automatic run_random(int unsigned count);
      int unsigned     sent;
      logic [OP_W-1:0] op;
      sent = 0;
      while (sent < count) begin
         op = pick_operation();
         send_item(op, pick_position(sb.walk_limit()), pick_value());
         if (op != OP_UNUSED) begin
            sent++;
            // sender pause halfway through each phase
            if (sent == count / 2) wait_for_results();
         end
      end
   endtask

   // hold the response side while queries keep coming, so the block backs up
   task automatic flood_while_held();
      hold_on = 1'b1;
      repeat (FLOOD_ITEMS)
         send_item(OP_QUERY, pick_position(sb.walk_limit()), pick_value());
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      logic [POS_W-1:0] sizes [PHASES];
      sb = new();
      sizes = '{13'd16, LAST_POS, 13'd0, TOP_POS, 13'd1, LAST_POS - 13'd1, 13'd0};
      sizes[PHASES-1] = POS_W'($urandom_range(2, TREE_SIZE - 1));

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      write_active_size(LAST_POS);
      run_directed();

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_for_results();
         repeat (SWEEP_CYCLES) @(posedge clock);
         write_active_size(sizes[ph]);
         if (ph < 3) begin
            send_idle_pct = 12;
            recv_idle_pct = 88;
         end else if (ph < 5) begin
            send_idle_pct = 88;
            recv_idle_pct = 12;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (ph == 5) flood_while_held();
         run_random(PHASE_ITEMS);
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      sb.check_drained();
      if (sb.failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> prefix_max_fenwick_tree.f
sv/pmft_pkg.sv
sv/prefix_max_fenwick_tree.sv
tb/sv/tb.sv
